[src/kvms_pkg.sv]
// Package for the key-value map store: action and entry tag codes,
// and the request and response word layouts.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kvms_pkg;

    // Action codes carried by a request word
    localparam logic [1:0] ACT_GET    = 2'd0;
    localparam logic [1:0] ACT_PUT    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // Slot tags kept in the entry RAM
    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_LIVE  = 2'd1;
    localparam logic [1:0] TAG_DEAD  = 2'd2;

    // Request word
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key;
        logic [31:0] value;
    } t_in_word;

    // Response word
    typedef struct packed {
        logic        found;
        logic [31:0] old_value;
        logic        full_res;
        logic [8:0]  entry_count;
    } t_out_word;

endpackage

`default_nettype wire

[src/kvms_chan_if.sv]
// Valid/ready channel interface with a typed payload word.
// No dependencies; the payload type is given at instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface kvms_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[src/kvms_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module kvms_ram #(
    parameter int unsigned WIDTH = 66,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[src/key_value_map_store_unit.sv]
// Key-value map store: open-addressed hash table in one entry RAM.
// Depends on kvms_pkg, kvms_chan_if and kvms_ram.
//
//   channel  | dir | word                                        | accepted when
//   ---------+-----+---------------------------------------------+--------------
//   i_req    | in  | action, key, value                          | valid & ready
//   o_rsp    | out | found, old_value, full_res, entry_count     | valid & ready
//
// Sequence: an accept state, a linear probe loop from the key's home bucket that
//   reads one entry RAM slot per cycle, and a write/result state; the probe stops
//   at the key, at an empty slot or once it has walked the whole table.
// Reset: a clearing pass marks every slot empty; no request is taken until it ends.
// Stalls: a held response blocks only the write/result cycle of the next word.
`timescale 1ns / 1ps
`default_nettype none

module key_value_map_store_unit #(
    parameter int unsigned CAPACITY   = 256,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 32
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    kvms_chan_if.sink   i_req,
    kvms_chan_if.source o_rsp
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = 2 + KEY_BITS + VALUE_BITS;

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_PROBE  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    typedef struct packed {
        logic [1:0]            tag;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    // Fold the key into a bucket index below CAPACITY
    function automatic logic [AW-1:0] bucket_of(input logic [KEY_BITS-1:0] k);
        logic [AW-1:0] f;
        logic [AW:0]   w;
        f = '0;
        for (int i = 0; i < KEY_BITS; i++) begin
            f[i % AW] = f[i % AW] ^ k[i];
        end
        w = {1'b0, f};
        if (w >= (AW + 1)'(CAPACITY)) begin
            w = w - (AW + 1)'(CAPACITY);
        end
        return w[AW-1:0];
    endfunction

    // Step to the next slot with wrap-around
    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
        return (a == AW'(CAPACITY - 1)) ? '0 : a + 1'b1;
    endfunction

    logic [1:0]            r_state, n_state;
    logic [AW-1:0]         r_addr, n_addr;
    logic [AW-1:0]         r_probe, n_probe;
    logic [1:0]            r_act, n_act;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic                  r_hit, n_hit;
    logic [AW-1:0]         r_slot, n_slot;
    logic                  r_have_free, n_have_free;
    logic [AW-1:0]         r_free, n_free;
    logic [VALUE_BITS-1:0] r_old, n_old;
    logic                  r_full, n_full;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    kvms_pkg::t_out_word   r_out, n_out;

    logic [KEY_BITS-1:0]   in_key;
    logic [VALUE_BITS-1:0] in_value;
    logic [AW-1:0]         rd_addr;
    logic [EW-1:0]         rd_data;
    t_entry                rd_entry;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    t_entry                wr_entry;
    logic                  is_hit;
    logic                  is_empty;
    logic                  is_last;
    logic                  stop;
    logic                  free_now;
    logic [AW-1:0]         free_pick;

    assign in_key   = KEY_BITS'(i_req.payload.key);
    assign in_value = VALUE_BITS'(i_req.payload.value);

    kvms_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_entry = rd_data;

    // Issue the home bucket while idle, the following slot while probing
    assign rd_addr = (r_state == S_PROBE) ? next_slot(r_addr) : bucket_of(in_key);

    // Examine the slot read for r_addr
    assign is_hit    = (rd_entry.tag == kvms_pkg::TAG_LIVE) && (rd_entry.key == r_key);
    assign is_empty  = (rd_entry.tag == kvms_pkg::TAG_EMPTY);
    assign is_last   = (r_probe == AW'(CAPACITY - 1));
    assign stop      = is_hit || is_empty || is_last;
    assign free_now  = r_have_free || is_empty || (rd_entry.tag == kvms_pkg::TAG_DEAD);
    assign free_pick = r_have_free ? r_free : r_addr;

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // Sequence clear, accept, probe and write-back
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_probe     = r_probe;
        n_act       = r_act;
        n_key       = r_key;
        n_value     = r_value;
        n_hit       = r_hit;
        n_slot      = r_slot;
        n_have_free = r_have_free;
        n_free      = r_free;
        n_old       = r_old;
        n_full      = r_full;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        wr_en       = 1'b0;
        wr_addr     = r_slot;
        wr_entry    = '{tag: kvms_pkg::TAG_LIVE, key: r_key, value: r_value};

        // Drop the response word once taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = r_addr;
                wr_entry = '{tag: kvms_pkg::TAG_EMPTY, key: '0, value: '0};
                n_addr   = next_slot(r_addr);
                if (r_addr == AW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_act       = i_req.payload.action;
                    n_key       = in_key;
                    n_value     = in_value;
                    n_addr      = bucket_of(in_key);
                    n_probe     = '0;
                    n_have_free = 1'b0;
                    n_state     = S_PROBE;
                end
            end
            S_PROBE: begin
                if (stop) begin
                    n_hit       = is_hit;
                    n_old       = is_hit ? rd_entry.value : '0;
                    n_slot      = is_hit ? r_addr : free_pick;
                    n_have_free = free_now;
                    n_full      = (r_act == kvms_pkg::ACT_PUT) && !is_hit
                                  && (r_count == CW'(CAPACITY));
                    n_state     = S_FINISH;
                end else begin
                    // Remember the first removed slot as insert target
                    if (rd_entry.tag == kvms_pkg::TAG_DEAD && !r_have_free) begin
                        n_have_free = 1'b1;
                        n_free      = r_addr;
                    end
                    n_addr  = next_slot(r_addr);
                    n_probe = r_probe + 1'b1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    if (r_act == kvms_pkg::ACT_PUT && !r_full) begin
                        wr_en = 1'b1;
                        if (!r_hit) begin
                            n_count = r_count + 1'b1;
                        end
                    end else if (r_act == kvms_pkg::ACT_REMOVE && r_hit) begin
                        wr_en    = 1'b1;
                        wr_entry = '{tag: kvms_pkg::TAG_DEAD, key: r_key, value: r_value};
                        n_count  = r_count - 1'b1;
                    end
                    n_out.found       = r_hit;
                    n_out.old_value   = 32'(r_old);
                    n_out.full_res    = r_full;
                    n_out.entry_count = 9'(n_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_probe     <= n_probe;
        r_act       <= n_act;
        r_key       <= n_key;
        r_value     <= n_value;
        r_hit       <= n_hit;
        r_slot      <= n_slot;
        r_have_free <= n_have_free;
        r_free      <= n_free;
        r_old       <= n_old;
        r_full      <= n_full;
        r_out       <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_write_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> !wr_en)
        else $error("entry RAM written during probe");

    a_insert_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && stop && !is_hit && r_act == kvms_pkg::ACT_PUT
         && r_count < CW'(CAPACITY)) |-> free_now)
        else $error("insert below capacity found no free slot");

    a_count_only_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FINISH) |=> (r_count == $past(r_count)))
        else $error("entry count changed outside write-back");

    a_rsp_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> ($past(r_state) == S_FINISH))
        else $error("response raised outside write-back");
`endif

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for key_value_map_store_unit: directed, fill, backpressure and random runs.
// Depends on kvms_pkg, kvms_chan_if and the store unit from src; results are predicted in-bench.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CAPACITY    = 256;
    localparam int unsigned RANDOM_OPS  = 130;
    localparam int unsigned DRAIN_EVERY = 65;
    localparam int unsigned FREE_STRIDE = 32;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PRINT_LIMIT = 40;

    // Action code that the block treats as a lookup
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;

    kvms_chan_if #(.t_payload(kvms_pkg::t_in_word))  req_if ();
    kvms_chan_if #(.t_payload(kvms_pkg::t_out_word)) rsp_if ();

    key_value_map_store_unit #(
        .CAPACITY  (CAPACITY),
        .KEY_BITS  (32),
        .VALUE_BITS(32)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Mirror of the store contents and the responses still owed
    bit [31:0]           stored_values [bit [31:0]];
    kvms_pkg::t_out_word pending_rsps [$];

    int unsigned error_count;
    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned hit_count;
    int unsigned refused_count;

    // Sender burst state
    int unsigned burst_left;

    // Receiver pattern state; the main thread raises hold_requests
    int unsigned hold_requests;
    int unsigned hold_served;
    int unsigned hold_left;
    int unsigned pattern_mode;
    int unsigned pattern_left;
    logic [7:0]  pattern_phase;

    int unsigned         idle_cycles;
    kvms_pkg::t_out_word due_rsp;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one request to the mirror and return the response it should produce
    function automatic kvms_pkg::t_out_word apply_request(kvms_pkg::t_in_word w);
        kvms_pkg::t_out_word r;
        logic                hit;
        r = '0;
        hit = stored_values.exists(w.key);
        r.found = hit;
        r.old_value = hit ? stored_values[w.key] : 32'd0;
        case (w.action)
            kvms_pkg::ACT_PUT: begin
                if (hit || stored_values.num() < CAPACITY) begin
                    stored_values[w.key] = w.value;
                end else begin
                    r.full_res = 1'b1;
                end
            end
            kvms_pkg::ACT_REMOVE: begin
                if (hit) begin
                    stored_values.delete(w.key);
                end
            end
            default: begin
            end
        endcase
        r.entry_count = 9'(stored_values.num());
        return r;
    endfunction

    function automatic kvms_pkg::t_in_word make_word(logic [1:0] action, logic [31:0] key,
                                                     logic [31:0] value);
        kvms_pkg::t_in_word w;
        w.action = action;
        w.key = key;
        w.value = value;
        return w;
    endfunction

    // Offer one word, with bursts and random gaps, and book its response on accept
    task automatic send_word(kvms_pkg::t_in_word w);
        int unsigned         gap;
        kvms_pkg::t_out_word r;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        repeat (gap) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.payload <= w;
        do @(posedge i_clk); while (!req_if.ready);
        r = apply_request(w);
        pending_rsps.push_back(r);
        words_sent++;
        burst_left--;
    endtask

    // Stop offering and wait until every owed response has come back
    task automatic drain_store;
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_rsps.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] fresh_key();
        logic [31:0] k;
        k = $urandom;
        while (stored_values.exists(k)) k = $urandom;
        return k;
    endfunction

    // Extremes of key and value, every action, zero values and absent keys
    task automatic test_directed_cases;
        send_word(make_word(kvms_pkg::ACT_GET,    32'h0000_0000, 32'hFFFF_FFFF));
        send_word(make_word(kvms_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000));
        send_word(make_word(kvms_pkg::ACT_PUT,    32'h0000_0000, 32'hFFFF_FFFF));
        send_word(make_word(kvms_pkg::ACT_PUT,    32'hFFFF_FFFF, 32'h0000_0000));
        send_word(make_word(kvms_pkg::ACT_GET,    32'hFFFF_FFFF, 32'h1234_5678));
        send_word(make_word(kvms_pkg::ACT_GET,    32'h0000_0000, 32'h0000_0000));
        send_word(make_word(kvms_pkg::ACT_PUT,    32'h0000_0000, 32'h1234_5678));
        send_word(make_word(ACT_UNUSED,           32'h0000_0000, 32'hDEAD_BEEF));
        send_word(make_word(ACT_UNUSED,           32'h8000_0001, 32'hDEAD_BEEF));
        send_word(make_word(kvms_pkg::ACT_PUT,    32'hA5A5_A5A5, 32'h5A5A_5A5A));
        send_word(make_word(kvms_pkg::ACT_PUT,    32'h5A5A_5A5A, 32'hA5A5_A5A5));
        send_word(make_word(kvms_pkg::ACT_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF));
        send_word(make_word(kvms_pkg::ACT_GET,    32'h0000_0000, 32'h0000_0000));
        send_word(make_word(kvms_pkg::ACT_REMOVE, 32'h0000_0000, 32'h0000_0000));
        send_word(make_word(kvms_pkg::ACT_PUT,    32'h0000_0000, 32'h0000_0000));
        send_word(make_word(kvms_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(make_word(kvms_pkg::ACT_GET,    32'hA5A5_A5A5, 32'hFFFF_FFFF));
        send_word(make_word(kvms_pkg::ACT_REMOVE, 32'hA5A5_A5A5, 32'h0000_0000));
        send_word(make_word(kvms_pkg::ACT_REMOVE, 32'h5A5A_5A5A, 32'h0000_0000));
        send_word(make_word(kvms_pkg::ACT_REMOVE, 32'h0000_0000, 32'h0000_0000));
        drain_store();
    endtask

    // Fill every slot, hit the full limit, free a few slots and refill them
    task automatic test_fill_to_capacity;
        bit [31:0]   held_keys [$];
        logic [31:0] k;
        while (stored_values.num() < CAPACITY) begin
            send_word(make_word(kvms_pkg::ACT_PUT, fresh_key(), $urandom));
        end
        k = fresh_key();
        send_word(make_word(kvms_pkg::ACT_PUT, k, $urandom));
        send_word(make_word(kvms_pkg::ACT_GET, k, $urandom));
        send_word(make_word(kvms_pkg::ACT_REMOVE, k, $urandom));
        foreach (stored_values[sk]) held_keys.push_back(sk);
        send_word(make_word(kvms_pkg::ACT_PUT, held_keys[0], 32'h0000_0000));
        send_word(make_word(kvms_pkg::ACT_GET, held_keys[0], $urandom));
        for (int i = 0; i < CAPACITY; i += FREE_STRIDE) begin
            send_word(make_word(kvms_pkg::ACT_REMOVE, held_keys[i], $urandom));
        end
        while (stored_values.num() < CAPACITY) begin
            send_word(make_word(kvms_pkg::ACT_PUT, fresh_key(), $urandom));
        end
        send_word(make_word(kvms_pkg::ACT_PUT, fresh_key(), $urandom));
        drain_store();
    endtask

    // Hold the response side off for a long stretch while requests keep coming
    task automatic test_output_backpressure;
        logic [31:0] k;
        hold_requests++;
        for (int i = 0; i < 40; i++) begin
            k = 32'h0000_0100 + 32'($urandom_range(0, 11));
            send_word(make_word(2'($urandom_range(0, 2)), k, $urandom));
        end
        drain_store();
    endtask

    // Mostly keys from a small pool so gets and removes hit; some fully random keys
    task automatic test_random_traffic;
        bit [31:0]   key_pool [$];
        logic [31:0] k;
        logic [31:0] v;
        logic [1:0]  act;
        int unsigned pick;
        key_pool.push_back(32'h0000_0000);
        key_pool.push_back(32'hFFFF_FFFF);
        key_pool.push_back(32'h8000_0000);
        key_pool.push_back(32'h0000_0001);
        while (key_pool.size() < 40) key_pool.push_back($urandom);
        for (int i = 0; i < RANDOM_OPS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) act = kvms_pkg::ACT_PUT;
            else if (pick < 70) act = kvms_pkg::ACT_GET;
            else if (pick < 95) act = kvms_pkg::ACT_REMOVE;
            else act = ACT_UNUSED;
            if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else k = $urandom;
            case ($urandom_range(0, 9))
                0: v = 32'h0000_0000;
                1: v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            send_word(make_word(act, k, v));
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1) drain_store();
        end
        drain_store();
    endtask

    // Main sequence
    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        error_count = 0;
        words_sent = 0;
        words_checked = 0;
        hit_count = 0;
        refused_count = 0;
        burst_left = 0;
        hold_requests = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();
        test_fill_to_capacity();

        repeat (CAPACITY + 8) @(posedge i_clk);
        $display("Covered %0d requests and %0d responses: %0d key hits, %0d full refusals,",
                 words_sent, words_checked, hit_count, refused_count);
        $display("a full table, freed-slot reuse, a long output hold and random traffic.");
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Response side: randomly chosen stall patterns, plus long holds
    initial begin
        rsp_if.ready = 1'b0;
        hold_served = 0;
        hold_left = 0;
        pattern_mode = 0;
        pattern_left = 0;
        pattern_phase = '0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern_mode = $urandom_range(0, 3);
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                pattern_phase++;
                case (pattern_mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= 1'($urandom_range(0, 1));
                    2: rsp_if.ready <= (pattern_phase[1:0] == 2'd0);
                    default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= PRINT_LIMIT) begin
                $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
            end
        end
    endtask

    // Compare each accepted response word with the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            words_checked++;
            if (pending_rsps.size() == 0) begin
                error_count++;
                if (error_count <= PRINT_LIMIT) begin
                    $display("%0t ns: unexpected response, expected none, got %h",
                             $time, rsp_if.payload);
                end
            end else begin
                due_rsp = pending_rsps.pop_front();
                if (due_rsp.found) hit_count++;
                if (due_rsp.full_res) refused_count++;
                check_field("found", 32'(due_rsp.found), 32'(rsp_if.payload.found));
                check_field("old_value", due_rsp.old_value, rsp_if.payload.old_value);
                check_field("full_res", 32'(due_rsp.full_res), 32'(rsp_if.payload.full_res));
                check_field("entry_count", 32'(due_rsp.entry_count),
                            32'(rsp_if.payload.entry_count));
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule
